// ===== rtl/llpm_pkg.sv =====
// Shared types and constants for the linked list pool manager.
// Used by every module of the block; depends on nothing else.
package llpm_pkg;

    // Default pool geometry.
    localparam int CAPACITY_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Widest index and word that the parameter ranges allow.
    localparam int IDX_MAX_W  = 11;
    localparam int DATA_MAX_W = 64;

    // Request codes.
    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_PLACE = 3'd1;
    localparam logic [2:0] REQ_APPEND    = 3'd2;
    localparam logic [2:0] REQ_DEL_FIRST = 3'd3;
    localparam logic [2:0] REQ_DEL_LAST  = 3'd4;
    localparam logic [2:0] REQ_DEL_VALUE = 3'd5;

    // Reply status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
        logic [5:0]         place;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         length;
        logic signed [31:0] removed_value;
    } t_rsp;

    // One write into the node pool; value and link share the address.
    typedef struct packed {
        logic                  we_value;
        logic                  we_link;
        logic [IDX_MAX_W-1:0]  addr;
        logic [IDX_MAX_W-1:0]  link;
        logic [DATA_MAX_W-1:0] value;
    } t_mem_wr;

endpackage

// ===== rtl/linked_list_pool_manager_top.sv =====
// Singly linked list of signed words in a fixed node pool with a free stack.
// Flow: a full pool is answered from the allocation state; front insert, delete first,
// empty and unknown requests are answered after one pool read; inserts past the front
// read one node at a time and end with the closing link write, deletes read the nodes after
// the head and end with a free stack write, all through the one pool read port. busy falls
// with the done strobe, so the next word can be accepted then. Synchronous active-low reset.
module linked_list_pool_manager_top #(
    parameter int CAPACITY   = llpm_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = llpm_pkg::DATA_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  llpm_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output llpm_pkg::t_rsp o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IW = $clog2(CAPACITY + 1);

    logic [DATA_WIDTH-1:0] word_ext;
    logic [DATA_WIDTH-1:0] rd_value;
    logic [IW-1:0]         rd_link;
    logic [AW-1:0]         rd_addr;
    llpm_pkg::t_mem_wr     mem_wr;
    logic [1:0]            status;
    logic [5:0]            count;
    logic [DATA_WIDTH-1:0] removed;

    // The incoming word is kept sign extended (or cut) to the stored width.
    assign word_ext = DATA_WIDTH'($signed(i_req.value));

    llpm_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_word     (word_ext),
        .i_place    (i_req.place),
        .i_rd_value (rd_value),
        .i_rd_link  (rd_link),
        .o_wr       (mem_wr),
        .o_rd_addr  (rd_addr),
        .o_busy     (busy),
        .o_done     (o_done),
        .o_status   (status),
        .o_count    (count),
        .o_removed  (removed)
    );

    llpm_pool #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_pool (
        .i_clk      (i_clk),
        .i_wr       (mem_wr),
        .i_rd_addr  (rd_addr),
        .o_rd_value (rd_value),
        .o_rd_link  (rd_link)
    );

    // A removed word narrower than the port is zero filled, a wider one is cut.
    assign o_rsp.status        = status;
    assign o_rsp.length        = count;
    assign o_rsp.removed_value = 32'(removed);

endmodule

// ===== rtl/llpm_pool.sv =====
// Node pool storage: word and next-link memories with one registered read port.
// Depends on llpm_pkg for the write request type.
module llpm_pool #(
    parameter int CAPACITY   = llpm_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = llpm_pkg::DATA_WIDTH_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int IW = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  llpm_pkg::t_mem_wr     i_wr,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_value,
    output logic [IW-1:0]         o_rd_link
);

    logic [DATA_WIDTH-1:0] mem_value [CAPACITY];
    logic [IW-1:0]         mem_link  [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rd_value;
    logic [IW-1:0]         r_rd_link;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_value) begin
            mem_value[i_wr.addr[AW-1:0]] <= i_wr.value[DATA_WIDTH-1:0];
        end
        if (i_wr.we_link) begin
            mem_link[i_wr.addr[AW-1:0]] <= i_wr.link[IW-1:0];
        end
        r_rd_value <= mem_value[i_rd_addr];
        r_rd_link  <= mem_link[i_rd_addr];
    end

    assign o_rd_value = r_rd_value;
    assign o_rd_link  = r_rd_link;

endmodule

// ===== rtl/llpm_seq.sv =====
// Request sequencer: walks the list one node per cycle through the pool read port,
// compares words and positions in a single shared compare stage. Depends on llpm_pkg.
module llpm_seq #(
    parameter int CAPACITY   = llpm_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = llpm_pkg::DATA_WIDTH_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int IW = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2:0]            i_req_type,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [5:0]            i_place,
    input  logic [DATA_WIDTH-1:0] i_rd_value,
    input  logic [IW-1:0]         i_rd_link,
    output llpm_pkg::t_mem_wr     o_wr,
    output logic [AW-1:0]         o_rd_addr,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [5:0]            o_count,
    output logic [DATA_WIDTH-1:0] o_removed
);

    localparam logic [IW-1:0] NIL   = IW'(CAPACITY);
    localparam logic [6:0]    P_SAT = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_ALLOC_D,
        S_WALK,
        S_LINK,
        S_HEAD,
        S_HEAD_D,
        S_FREE
    } t_state;

    t_state                r_state,   n_state;
    logic [2:0]            r_req,     n_req;
    logic [DATA_WIDTH-1:0] r_word,    n_word;
    logic [5:0]            r_place,   n_place;
    logic [IW-1:0]         r_head,    n_head;
    logic [IW-1:0]         r_free,    n_free;
    logic [IW-1:0]         r_fresh,   n_fresh;
    logic [IW-1:0]         r_count,   n_count;
    logic [IW-1:0]         r_node,    n_node;
    logic [IW-1:0]         r_cur,     n_cur;
    logic [IW-1:0]         r_prev,    n_prev;
    logic [IW-1:0]         r_tmp,     n_tmp;
    logic [6:0]            r_p,       n_p;
    logic [1:0]            r_status,  n_status;
    logic [DATA_WIDTH-1:0] r_removed, n_removed;
    logic                  r_done,    n_done;

    logic [IW-1:0]     rd_idx;
    logic [IW-1:0]     alloc_idx;
    logic              word_hit;
    logic              link_nil;
    logic              place_hit;
    logic              at_front;
    llpm_pkg::t_mem_wr wr;

    // The shared compare stage: all decisions of a walk step come from here.
    assign word_hit  = (i_rd_value == r_word);
    assign link_nil  = (i_rd_link == NIL);
    assign place_hit = (r_req == llpm_pkg::REQ_INS_PLACE) && (r_p == {1'b0, r_place});
    assign alloc_idx = (r_free != NIL) ? r_free : r_fresh;
    assign at_front  = (r_req == llpm_pkg::REQ_INS_FRONT) || (r_head == NIL)
                     || ((r_req == llpm_pkg::REQ_INS_PLACE) && (r_place == 6'd1));

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_word    = r_word;
        n_place   = r_place;
        n_head    = r_head;
        n_free    = r_free;
        n_fresh   = r_fresh;
        n_count   = r_count;
        n_node    = r_node;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_tmp     = r_tmp;
        n_p       = r_p;
        n_status  = r_status;
        n_removed = r_removed;
        n_done    = 1'b0;
        rd_idx    = r_head;
        wr        = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req     = i_req_type;
                    n_word    = i_word;
                    n_place   = i_place;
                    n_removed = '0;
                    n_state   = (i_req_type <= llpm_pkg::REQ_APPEND) ? S_ALLOC : S_HEAD;
                end
            end
            S_ALLOC: begin
                // Fetch the link of the free stack top so it can be popped.
                rd_idx = r_free;
                if (r_count >= NIL) begin
                    n_status = llpm_pkg::ST_FULL;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_ALLOC_D;
                end
            end
            S_ALLOC_D: begin
                if (r_free != NIL) begin
                    n_free = i_rd_link;
                end else begin
                    n_fresh = r_fresh + 1'b1;
                end
                n_node       = alloc_idx;
                n_count      = r_count + 1'b1;
                wr.we_value  = 1'b1;
                wr.addr      = llpm_pkg::IDX_MAX_W'(alloc_idx);
                wr.value     = llpm_pkg::DATA_MAX_W'(r_word);
                if (at_front) begin
                    wr.we_link = 1'b1;
                    wr.link    = llpm_pkg::IDX_MAX_W'(r_head);
                    n_head     = alloc_idx;
                    n_status   = llpm_pkg::ST_OK;
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    rd_idx  = r_head;
                    n_cur   = r_head;
                    n_p     = 7'd2;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // The read data belongs to node r_cur.
                if (r_req <= llpm_pkg::REQ_APPEND) begin
                    if (place_hit || link_nil) begin
                        wr.we_link = 1'b1;
                        wr.addr    = llpm_pkg::IDX_MAX_W'(r_cur);
                        wr.link    = llpm_pkg::IDX_MAX_W'(r_node);
                        n_tmp      = i_rd_link;
                        n_state    = S_LINK;
                    end else begin
                        rd_idx = i_rd_link;
                        n_cur  = i_rd_link;
                        if (r_p != P_SAT) begin
                            n_p = r_p + 1'b1;
                        end
                    end
                end else if ((r_req == llpm_pkg::REQ_DEL_LAST && link_nil)
                             || (r_req == llpm_pkg::REQ_DEL_VALUE && word_hit)) begin
                    n_removed  = i_rd_value;
                    wr.we_link = 1'b1;
                    wr.addr    = llpm_pkg::IDX_MAX_W'(r_prev);
                    wr.link    = llpm_pkg::IDX_MAX_W'(i_rd_link);
                    n_node     = r_cur;
                    n_state    = S_FREE;
                end else if (link_nil) begin
                    n_status = llpm_pkg::ST_MISSING;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    rd_idx = i_rd_link;
                    n_prev = r_cur;
                    n_cur  = i_rd_link;
                end
            end
            S_LINK: begin
                wr.we_link = 1'b1;
                wr.addr    = llpm_pkg::IDX_MAX_W'(r_node);
                wr.link    = llpm_pkg::IDX_MAX_W'(r_tmp);
                n_status   = llpm_pkg::ST_OK;
                n_done     = 1'b1;
                n_state    = S_IDLE;
            end
            S_HEAD: begin
                rd_idx  = r_head;
                n_state = S_HEAD_D;
            end
            S_HEAD_D: begin
                if (r_req > llpm_pkg::REQ_DEL_VALUE) begin
                    n_status = llpm_pkg::ST_OK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_head == NIL) begin
                    n_status = llpm_pkg::ST_EMPTY;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if ((r_req == llpm_pkg::REQ_DEL_FIRST)
                             || (r_req == llpm_pkg::REQ_DEL_VALUE && word_hit)
                             || (r_req == llpm_pkg::REQ_DEL_LAST && link_nil)) begin
                    // The head goes back on top of the free stack.
                    n_removed  = i_rd_value;
                    n_head     = i_rd_link;
                    wr.we_link = 1'b1;
                    wr.addr    = llpm_pkg::IDX_MAX_W'(r_head);
                    wr.link    = llpm_pkg::IDX_MAX_W'(r_free);
                    n_free     = r_head;
                    n_count    = r_count - 1'b1;
                    n_status   = llpm_pkg::ST_OK;
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end else if (link_nil) begin
                    n_status = llpm_pkg::ST_MISSING;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    rd_idx  = i_rd_link;
                    n_prev  = r_head;
                    n_cur   = i_rd_link;
                    n_state = S_WALK;
                end
            end
            S_FREE: begin
                wr.we_link = 1'b1;
                wr.addr    = llpm_pkg::IDX_MAX_W'(r_node);
                wr.link    = llpm_pkg::IDX_MAX_W'(r_free);
                n_free     = r_node;
                n_count    = r_count - 1'b1;
                n_status   = llpm_pkg::ST_OK;
                n_done     = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NIL;
            r_free  <= NIL;
            r_fresh <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_fresh <= n_fresh;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_req     <= n_req;
        r_word    <= n_word;
        r_place   <= n_place;
        r_node    <= n_node;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_tmp     <= n_tmp;
        r_p       <= n_p;
        r_status  <= n_status;
        r_removed <= n_removed;
    end

    assign o_wr      = wr;
    assign o_rd_addr = rd_idx[AW-1:0];
    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_status  = r_status;
    assign o_count   = 6'(r_count);
    assign o_removed = r_removed;

endmodule

// ===== rtl/llpm_checker.sv =====
// Port-level checks for the linked list pool manager, bound to the top level.
// Depends on llpm_pkg for the request, reply and status definitions.
module llpm_checker #(
    parameter int CAPACITY = llpm_pkg::CAPACITY_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input llpm_pkg::t_rsp o_rsp
);

    // An accepted word always takes the block out of idle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block stayed idle after accepting a word");

    // The reply comes from an active request and frees the block at once.
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("reply strobe without a finishing request");

    // A pool full reply means every node is in use.
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == llpm_pkg::ST_FULL) |-> (o_rsp.length == 6'(CAPACITY)))
        else $error("pool full reported with free nodes left");

    // An empty reply has zero length, and failed requests remove nothing.
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == llpm_pkg::ST_EMPTY) |-> (o_rsp.length == 6'd0))
        else $error("list empty reported with nodes on the list");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != llpm_pkg::ST_OK) |-> (o_rsp.removed_value == 32'sd0))
        else $error("failed request reported a removed word");

endmodule

bind linked_list_pool_manager_top llpm_checker #(
    .CAPACITY (CAPACITY)
) u_llpm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
